// ----- rtl/core/dwip_pkg.sv -----
`default_nettype none
package dwip_pkg;

	// block constants
	localparam int PWM_PERIOD = 6000;
	localparam int FRAC_BITS  = 8;

	// field and datapath widths
	localparam int GAIN_W   = 16;
	localparam int SPD_W    = 16;
	localparam int ERR_W    = 17;
	localparam int DP_W     = 18;
	localparam int DD_W     = 20;
	localparam int MUL_A_W  = 17;
	localparam int MUL_B_W  = 27;
	localparam int PROD_W   = 44;
	localparam int TERM_W   = 52;
	localparam int ITERM_W  = 40;
	localparam int ACC_W    = 32;
	localparam int DUTY_W   = 8;
	localparam int MAG_W    = 7;
	localparam int CMP_W    = 13;
	localparam int LIM_W    = 7;
	localparam int SUM_W    = 34;
	localparam int ADDR_W   = 5;
	localparam int APB_W    = 32;

	// q.8 product to accumulator format
	localparam int UP_SHIFT = (FRAC_BITS >= 8) ? (FRAC_BITS - 8) : 0;
	localparam int DN_SHIFT = (FRAC_BITS >= 8) ? 0 : (8 - FRAC_BITS);

	// i term blend weights over 256
	localparam int BLEND_NEW   = 230;
	localparam int BLEND_OLD   = 26;
	localparam int BLEND_SHIFT = 8;

	localparam longint I_MAX_L = (longint'(1) <<< (ITERM_W - 1)) - 1;
	localparam longint I_MIN_L = -(longint'(1) <<< (ITERM_W - 1));

	// compare = floor(mag * PWM_PERIOD / 100) as mag * K >> CMP_SHIFT
	localparam int     CMP_SHIFT = 16;
	localparam longint COMPARE_K = (longint'(PWM_PERIOD) * (longint'(1) <<< CMP_SHIFT) + 99) / 100;

	localparam logic [LIM_W-1:0] DUTY_MAX = 7'd100;

	// register map
	typedef enum logic [2:0] {
		REG_PROP  = 3'd0,
		REG_INTEG = 3'd1,
		REG_DERIV = 3'd2,
		REG_FF    = 3'd3,
		REG_LIMIT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] prop_gain;
		logic signed [GAIN_W-1:0] integ_gain;
		logic signed [GAIN_W-1:0] deriv_gain;
		logic signed [GAIN_W-1:0] ff_gain;
		logic        [LIM_W-1:0]  duty_limit;
	} cfg_t;

	typedef struct packed {
		logic                      en;
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_I,
		ST_BLEND,
		ST_ITERM,
		ST_ACC,
		ST_MUL_F,
		ST_DUTY,
		ST_MUL_C,
		ST_CMP,
		ST_DONE
	} state_t;

	// scale a q.8 product to the accumulator fraction
	function automatic logic signed [TERM_W-1:0] q8_to_acc(input logic signed [PROD_W-1:0] x);
		logic signed [TERM_W-1:0] w;
		w = TERM_W'(x);
		w = w <<< UP_SHIFT;
		return w >>> DN_SHIFT;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/dual_wheel_incremental_pid.sv -----
`default_nettype none
// channel  | dir | handshake            | payload
// s_*      | in  | s_tvalid / s_tready  | s_tdata: targets, measured speeds; s_tuser: track_lost
// m_*      | out | m_tvalid / m_tready  | m_tdata: duty, reverse, compare for both wheels
// apb      | in  | psel/penable/pready  | gain and duty limit registers at 4*index
//
// a tracked tick runs 11 sequencer steps per wheel through the one shared multiplier,
// then one output load step and one idle step before the next accept.
// a track-lost tick goes straight to the output load and changes no controller state.
// reset clears the controller state and the registers to their defaults.
// the output register holds until taken; the sequencer waits in its last step if
// the previous result is still pending, and s_tready is high only when idle.
module dual_wheel_incremental_pid import dwip_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [APB_W-1:0]  pwdata,
	output logic      [APB_W-1:0]  prdata,
	output logic                   pready,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// left_target, left_measured, right_target, right_measured
	input  wire logic [63:0]       s_tdata,
	// track_lost
	input  wire logic              s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// left_duty, left_reverse, left_compare, right_duty, right_reverse,
	// right_compare, zero pad
	output logic [47:0]            m_tdata
);

	cfg_t     cfg;
	mul_req_t mreq;
	logic signed [PROD_W-1:0] prod;

	state_t state_q, state_d;
	logic   wheel_q;
	logic   lost_q;
	logic   m_valid_q;
	logic [47:0] m_data_q;
	logic   load_out;

	logic signed [SPD_W-1:0]   tgt_q   [2];
	logic signed [SPD_W-1:0]   meas_q  [2];
	logic signed [ACC_W-1:0]   accum_q [2];
	logic signed [ERR_W-1:0]   elast_q [2];
	logic signed [ERR_W-1:0]   eprev_q [2];
	logic signed [ITERM_W-1:0] ilast_q [2];
	logic signed [DUTY_W-1:0]  duty_q  [2];
	logic        [CMP_W-1:0]   cmp_q   [2];

	logic signed [ERR_W-1:0]   err_q;
	logic signed [TERM_W-1:0]  sum_q;
	logic signed [TERM_W-1:0]  blend_q;
	logic signed [ITERM_W-1:0] iterm_q;
	logic signed [DUTY_W-1:0]  whole_q;

	dwip_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dwip_mul u_mul (
		.clk  (clk),
		.req  (mreq),
		.prod (prod)
	);

	// current wheel operands
	logic signed [SPD_W-1:0]  tgt, meas;
	logic signed [ERR_W-1:0]  le, pe;
	logic signed [ERR_W-1:0]  err_next;
	logic signed [DP_W-1:0]   dp;
	logic signed [DD_W-1:0]   dd;
	logic signed [TERM_W-1:0] term;
	logic [LIM_W-1:0]         lim_eff;

	assign tgt      = tgt_q[wheel_q];
	assign meas     = meas_q[wheel_q];
	assign le       = elast_q[wheel_q];
	assign pe       = eprev_q[wheel_q];
	assign err_next = ERR_W'(tgt) - ERR_W'(meas);
	assign dp       = DP_W'(err_q) - DP_W'(le);
	assign dd       = DD_W'(err_q) - (DD_W'(le) <<< 1) + DD_W'(pe);
	assign term     = q8_to_acc(prod);
	assign lim_eff  = (cfg.duty_limit > DUTY_MAX) ? DUTY_MAX : cfg.duty_limit;

	// i term blend and saturation
	logic signed [TERM_W-1:0] blend_next, isum, ishift, isat;
	assign blend_next = term * TERM_W'(BLEND_NEW);
	assign isum       = blend_q + TERM_W'(ilast_q[wheel_q]) * TERM_W'(BLEND_OLD);
	assign ishift     = isum >>> BLEND_SHIFT;
	always_comb begin
		if (ishift > TERM_W'(I_MAX_L)) begin
			isat = TERM_W'(I_MAX_L);
		end else if (ishift < TERM_W'(I_MIN_L)) begin
			isat = TERM_W'(I_MIN_L);
		end else begin
			isat = ishift;
		end
	end

	// accumulator update and clamp
	logic signed [TERM_W-1:0] lim_acc, acc_sum, acc_clamp;
	assign lim_acc = TERM_W'({1'b0, lim_eff}) <<< FRAC_BITS;
	assign acc_sum = sum_q + TERM_W'(iterm_q);
	always_comb begin
		if (acc_sum > lim_acc) begin
			acc_clamp = lim_acc;
		end else if (acc_sum < -lim_acc) begin
			acc_clamp = -lim_acc;
		end else begin
			acc_clamp = acc_sum;
		end
	end

	// whole part of the accumulator, toward zero
	logic signed [ACC_W-1:0] acc_cur, whole_full;
	logic                    whole_up;
	assign acc_cur    = accum_q[wheel_q];
	assign whole_up   = acc_cur[ACC_W-1] && (acc_cur[FRAC_BITS-1:0] != '0);
	assign whole_full = (acc_cur >>> FRAC_BITS) + $signed(ACC_W'(whole_up));

	// duty with feedforward, toward zero, clamped
	logic signed [SUM_W-1:0] ff_sum, ff_div, lim_s, duty_c;
	logic                    ff_up;
	assign ff_sum = (SUM_W'(whole_q) <<< 8) + SUM_W'(prod);
	assign ff_up  = ff_sum[SUM_W-1] && (ff_sum[7:0] != '0);
	assign ff_div = (ff_sum >>> 8) + $signed(SUM_W'(ff_up));
	assign lim_s  = SUM_W'({1'b0, lim_eff});
	always_comb begin
		if (ff_div > lim_s) begin
			duty_c = lim_s;
		end else if (ff_div < -lim_s) begin
			duty_c = -lim_s;
		end else begin
			duty_c = ff_div;
		end
	end

	// magnitude for the compare value
	logic signed [DUTY_W-1:0] duty_cur, mag_full;
	assign duty_cur = duty_q[wheel_q];
	assign mag_full = duty_cur[DUTY_W-1] ? -duty_cur : duty_cur;

	// sequencer next state, multiplier requests, handshake
	always_comb begin
		state_d  = state_q;
		mreq     = '0;
		s_tready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = s_tuser ? ST_DONE : ST_ERR;
				end
			end
			ST_ERR: state_d = ST_MUL_P;
			ST_MUL_P: begin
				mreq.en = 1'b1;
				mreq.a  = MUL_A_W'(cfg.prop_gain);
				mreq.b  = MUL_B_W'(dp);
				state_d = ST_MUL_D;
			end
			ST_MUL_D: begin
				mreq.en = 1'b1;
				mreq.a  = MUL_A_W'(cfg.deriv_gain);
				mreq.b  = MUL_B_W'(dd);
				state_d = ST_MUL_I;
			end
			ST_MUL_I: begin
				mreq.en = 1'b1;
				mreq.a  = MUL_A_W'(cfg.integ_gain);
				mreq.b  = MUL_B_W'(err_q);
				state_d = ST_BLEND;
			end
			ST_BLEND: state_d = ST_ITERM;
			ST_ITERM: state_d = ST_ACC;
			ST_ACC:   state_d = ST_MUL_F;
			ST_MUL_F: begin
				mreq.en = 1'b1;
				mreq.a  = MUL_A_W'(cfg.ff_gain);
				mreq.b  = MUL_B_W'(tgt);
				state_d = ST_DUTY;
			end
			ST_DUTY: state_d = ST_MUL_C;
			ST_MUL_C: begin
				mreq.en = 1'b1;
				mreq.a  = MUL_A_W'({1'b0, mag_full[MAG_W-1:0]});
				mreq.b  = MUL_B_W'(COMPARE_K);
				state_d = ST_CMP;
			end
			ST_CMP: state_d = wheel_q ? ST_DONE : ST_ERR;
			ST_DONE: begin
				if (!m_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_q   <= 1'b0;
			lost_q    <= 1'b0;
			m_valid_q <= 1'b0;
			for (int w = 0; w < 2; w++) begin
				accum_q[w] <= '0;
				elast_q[w] <= '0;
				eprev_q[w] <= '0;
				ilast_q[w] <= '0;
			end
		end else begin
			if (s_tvalid && s_tready) begin
				wheel_q <= 1'b0;
				lost_q  <= s_tuser;
			end else if (state_q == ST_CMP) begin
				wheel_q <= 1'b1;
			end
			if (state_q == ST_ACC) begin
				accum_q[wheel_q] <= ACC_W'(acc_clamp);
				ilast_q[wheel_q] <= iterm_q;
				eprev_q[wheel_q] <= le;
				elast_q[wheel_q] <= err_q;
			end
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tgt_q[0]  <= s_tdata[15:0];
			meas_q[0] <= s_tdata[31:16];
			tgt_q[1]  <= s_tdata[47:32];
			meas_q[1] <= s_tdata[63:48];
		end
		case (state_q)
			ST_ERR:   err_q <= err_next;
			ST_MUL_D: sum_q <= TERM_W'(acc_cur) + term;
			ST_MUL_I: sum_q <= sum_q + term;
			ST_BLEND: blend_q <= blend_next;
			ST_ITERM: iterm_q <= ITERM_W'(isat);
			ST_MUL_F: whole_q <= DUTY_W'(whole_full);
			ST_DUTY:  duty_q[wheel_q] <= DUTY_W'(duty_c);
			ST_CMP:   cmp_q[wheel_q] <= prod[CMP_SHIFT +: CMP_W];
			default: ;
		endcase
		if (load_out) begin
			if (lost_q) begin
				m_data_q <= '0;
			end else begin
				m_data_q <= {4'b0, cmp_q[1], duty_q[1][DUTY_W-1], duty_q[1],
					cmp_q[0], duty_q[0][DUTY_W-1], duty_q[0]};
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
`default_nettype wire

// ----- rtl/core/dwip_cfg.sv -----
`default_nettype none
module dwip_cfg import dwip_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [APB_W-1:0]  pwdata,
	output logic      [APB_W-1:0]  prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	localparam logic signed [GAIN_W-1:0] RESET_PROP  = 16'sd256;
	localparam logic        [LIM_W-1:0]  RESET_LIMIT = 7'd90;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain  <= RESET_PROP;
			cfg_q.integ_gain <= '0;
			cfg_q.deriv_gain <= '0;
			cfg_q.ff_gain    <= '0;
			cfg_q.duty_limit <= RESET_LIMIT;
		end else if (wr_en) begin
			case (idx)
				REG_PROP:  cfg_q.prop_gain  <= pwdata[GAIN_W-1:0];
				REG_INTEG: cfg_q.integ_gain <= pwdata[GAIN_W-1:0];
				REG_DERIV: cfg_q.deriv_gain <= pwdata[GAIN_W-1:0];
				REG_FF:    cfg_q.ff_gain    <= pwdata[GAIN_W-1:0];
				REG_LIMIT: cfg_q.duty_limit <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_PROP:  prdata = APB_W'(cfg_q.prop_gain[GAIN_W-1:0]);
			REG_INTEG: prdata = APB_W'(cfg_q.integ_gain[GAIN_W-1:0]);
			REG_DERIV: prdata = APB_W'(cfg_q.deriv_gain[GAIN_W-1:0]);
			REG_FF:    prdata = APB_W'(cfg_q.ff_gain[GAIN_W-1:0]);
			REG_LIMIT: prdata = APB_W'(cfg_q.duty_limit);
			default:   prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/dwip_mul.sv -----
`default_nettype none
module dwip_mul import dwip_pkg::*; (
	input  wire logic                     clk,
	input  wire mul_req_t                 req,
	output logic signed [PROD_W-1:0]      prod
);

	logic signed [PROD_W-1:0] prod_q;

	assign prod = prod_q;

	// shared signed multiplier, product registered
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= PROD_W'(req.a) * PROD_W'(req.b);
		end
	end

endmodule
`default_nettype wire

// ----- tb/tb_dual_wheel_incremental_pid.sv -----
`timescale 1ns / 1ps

module tb_dual_wheel_incremental_pid;
	import dwip_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_AFTER  = 100;
	localparam int HOLD_CYCLES = 500;
	localparam int PRINT_MAX   = 40;

	// one request: wheel speeds and track flag, laid out as on s_tdata / s_tuser
	typedef struct packed {
		logic                    lost;
		logic signed [SPD_W-1:0] rm;
		logic signed [SPD_W-1:0] rt;
		logic signed [SPD_W-1:0] lm;
		logic signed [SPD_W-1:0] lt;
	} tick_t;

	// one wheel of a result, laid out as on m_tdata
	typedef struct packed {
		logic [CMP_W-1:0]         cmp;
		logic                     rev;
		logic signed [DUTY_W-1:0] duty;
	} wheel_out_t;

	// index 0 is the left wheel
	typedef wheel_out_t [1:0] duty_pair_t;

	logic              clk;
	logic              arst_n   = 1'b0;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [APB_W-1:0]  pwdata   = '0;
	logic [APB_W-1:0]  prdata;
	logic              pready;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [47:0]       m_tdata;
	tick_t             cur_tick = '0;

	// controller settings and per-wheel state as the block should hold them
	logic signed [GAIN_W-1:0] kp   = 16'sd256;
	logic signed [GAIN_W-1:0] ki   = 16'sd0;
	logic signed [GAIN_W-1:0] kd   = 16'sd0;
	logic signed [GAIN_W-1:0] kf   = 16'sd0;
	logic [LIM_W-1:0]         klim = 7'd90;
	longint acc_out[2]    = '{0, 0};
	longint err_last[2]   = '{0, 0};
	longint err_prev[2]   = '{0, 0};
	longint iterm_last[2] = '{0, 0};

	tick_t      pending_ticks[$];
	duty_pair_t expected_duties[$];
	duty_pair_t got_duties;
	duty_pair_t want_duties;

	int   err_count    = 0;
	int   results_seen = 0;
	int   cycles       = 0;
	logic s_fire       = 1'b0;
	int   tx_gap       = 0;
	int   tx_calm      = 0;
	int   rx_gap       = 0;
	int   rx_calm      = 0;
	int   hold_left    = 0;
	logic hold_done    = 1'b0;

	dual_wheel_incremental_pid u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		// left_target, left_measured, right_target, right_measured
		.s_tdata  (cur_tick[63:0]),
		// track_lost
		.s_tuser  (cur_tick.lost),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		// left_duty, left_reverse, left_compare, right_duty, right_reverse,
		// right_compare, zero pad
		.m_tdata  (m_tdata)
	);

	// clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// q.8 product to accumulator fraction, floor when narrowing
	function automatic longint to_acc(longint x);
		if (FRAC_BITS >= 8) return x <<< (FRAC_BITS - 8);
		return x >>> (8 - FRAC_BITS);
	endfunction

	function automatic longint limit_to(longint x, longint lim);
		if (x > lim) return lim;
		if (x < -lim) return -lim;
		return x;
	endfunction

	// one incremental pid step for one wheel, updates that wheel's state
	function automatic wheel_out_t wheel_step(int w, longint tgt, longint meas, longint lim);
		longint err, le, pe, p, d, inew, iterm, acc, whole, sum, duty, mag;
		wheel_out_t o;
		err   = tgt - meas;
		le    = err_last[w];
		pe    = err_prev[w];
		p     = to_acc(longint'(kp) * (err - le));
		d     = to_acc(longint'(kd) * (err - 2 * le + pe));
		inew  = to_acc(longint'(ki) * err);
		iterm = (BLEND_NEW * inew + BLEND_OLD * iterm_last[w]) >>> BLEND_SHIFT;
		if (iterm > I_MAX_L) iterm = I_MAX_L;
		if (iterm < I_MIN_L) iterm = I_MIN_L;
		acc = limit_to(acc_out[w] + p + iterm + d, lim <<< FRAC_BITS);
		acc_out[w]    = acc;
		iterm_last[w] = iterm;
		err_prev[w]   = le;
		err_last[w]   = err;
		// truncate toward zero, add feedforward, truncate again
		whole = acc / (longint'(1) <<< FRAC_BITS);
		sum   = whole * 256 + longint'(kf) * tgt;
		duty  = limit_to(sum / 256, lim);
		mag   = (duty < 0) ? -duty : duty;
		o.duty = DUTY_W'(duty);
		o.rev  = (duty < 0);
		o.cmp  = CMP_W'(mag * PWM_PERIOD / 100);
		return o;
	endfunction

	// duties for one control tick; track lost gives zeros and leaves state alone
	function automatic duty_pair_t pid_tick(tick_t t);
		duty_pair_t o;
		longint lim;
		o   = '0;
		lim = (klim > DUTY_MAX) ? longint'(DUTY_MAX) : longint'(klim);
		if (!t.lost) begin
			o[0] = wheel_step(0, $signed(t.lt), $signed(t.lm), lim);
			o[1] = wheel_step(1, $signed(t.rt), $signed(t.rm), lim);
		end
		return o;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 10);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [GAIN_W-1:0] rand_gain();
		if ($urandom_range(0, 99) < 80) return GAIN_W'(int'($urandom_range(0, 1024)) - 512);
		return GAIN_W'($urandom);
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		if (err_count < PRINT_MAX)
			$display("[%0t] mismatch on %s: got %0d, want %0d", $time, field, got, want);
		err_count++;
	endtask

	// apb write with readback, model settings follow the write
	task automatic write_reg(reg_idx_t idx, logic [APB_W-1:0] val);
		logic [APB_W-1:0] mask;
		mask = (idx == REG_LIMIT) ? APB_W'((1 << LIM_W) - 1) : APB_W'((1 << GAIN_W) - 1);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(4 * int'(idx));
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_PROP:  kp   = val[GAIN_W-1:0];
			REG_INTEG: ki   = val[GAIN_W-1:0];
			REG_DERIV: kd   = val[GAIN_W-1:0];
			REG_FF:    kf   = val[GAIN_W-1:0];
			REG_LIMIT: klim = val[LIM_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) !== (val & mask))
			report_mismatch("register readback", prdata & mask, val & mask);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_gains(logic [GAIN_W-1:0] p, logic [GAIN_W-1:0] i,
			logic [GAIN_W-1:0] d, logic [GAIN_W-1:0] f, logic [LIM_W-1:0] lim);
		write_reg(REG_PROP, APB_W'(p));
		write_reg(REG_INTEG, APB_W'(i));
		write_reg(REG_DERIV, APB_W'(d));
		write_reg(REG_FF, APB_W'(f));
		write_reg(REG_LIMIT, APB_W'(lim));
		@(posedge clk);
	endtask

	task automatic add_tick(logic [15:0] lt, logic [15:0] lm, logic [15:0] rt,
			logic [15:0] rm, logic lost);
		tick_t t;
		t.lt   = lt;
		t.lm   = lm;
		t.rt   = rt;
		t.rm   = rm;
		t.lost = lost;
		pending_ticks.push_back(t);
	endtask

	// mostly plausible speed pairs, some raw bit patterns, some lost track
	task automatic add_random_ticks(int n);
		tick_t t;
		int r;
		int span;
		repeat (n) begin
			r = $urandom_range(0, 99);
			t[63:0] = {$urandom, $urandom};
			t.lost  = (r < 10);
			if (r >= 40) begin
				span = ($urandom_range(0, 9) == 0) ? 4000 : 400;
				t.lt = SPD_W'(int'($urandom_range(0, 2 * span)) - span);
				t.lm = SPD_W'($signed(t.lt) + int'($urandom_range(0, 60)) - 30);
				t.rt = SPD_W'(int'($urandom_range(0, 2 * span)) - span);
				t.rm = SPD_W'($signed(t.rt) + int'($urandom_range(0, 60)) - 30);
			end
			pending_ticks.push_back(t);
		end
	endtask

	// wait for every request taken and every result back, then let the block settle
	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (pending_ticks.size() != 0 || s_tvalid || expected_duties.size() != 0);
		repeat (30) @(posedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (tx_calm > 0) tx_calm <= tx_calm - 1;
		else if ($urandom_range(0, 299) == 0) tx_calm <= 150;
		if (arst_n && !(s_tvalid && !s_fire)) begin
			if (tx_gap > 0) begin
				tx_gap   <= tx_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_ticks.size() > 0) begin
				cur_tick <= pending_ticks.pop_front();
				s_tvalid <= 1'b1;
				tx_gap   <= (tx_calm > 0 || $urandom_range(0, 99) < 55) ? 0 : idle_len();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (rx_calm > 0) rx_calm <= rx_calm - 1;
		else if ($urandom_range(0, 299) == 0) rx_calm <= 150;
		if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap   <= rx_gap - 1;
			m_tready <= 1'b0;
		end else if (rx_calm == 0 && $urandom_range(0, 99) < 20) begin
			rx_gap   <= idle_len() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// check results, then predict for the request taken at this edge
	always @(posedge clk) begin
		s_fire <= s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (expected_duties.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				want_duties = expected_duties.pop_front();
				got_duties  = duty_pair_t'(m_tdata[43:0]);
				for (int w = 0; w < 2; w++) begin
					if (got_duties[w].duty !== want_duties[w].duty)
						report_mismatch({w ? "right" : "left", "_duty"},
							$signed(got_duties[w].duty), $signed(want_duties[w].duty));
					if (got_duties[w].rev !== want_duties[w].rev)
						report_mismatch({w ? "right" : "left", "_reverse"},
							got_duties[w].rev, want_duties[w].rev);
					if (got_duties[w].cmp !== want_duties[w].cmp)
						report_mismatch({w ? "right" : "left", "_compare"},
							got_duties[w].cmp, want_duties[w].cmp);
				end
			end
		end
		if (arst_n && s_tvalid && s_tready)
			expected_duties.push_back(pid_tick(cur_tick));
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// stimulus
	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero, full-scale errors both ways, lost track, patterns
		add_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		add_tick(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b0);
		add_tick(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b0);
		add_tick(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1);
		add_tick(16'd20, 16'd0, 16'hffec, 16'd0, 1'b0);
		add_tick(16'd20, 16'd0, 16'hffec, 16'd0, 1'b0);
		add_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
		add_tick(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 1'b0);
		add_tick(16'd5, 16'd7, 16'd0, 16'd1, 1'b0);
		wait_idle();

		// extreme gains with a limit above the duty ceiling
		load_gains(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 7'd127);
		add_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		add_tick(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b0);
		add_tick(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b0);
		add_tick(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 1'b1);
		add_tick(16'd3, 16'd1, 16'hfffd, 16'hffff, 1'b0);
		add_tick(16'h0001, 16'h0000, 16'hffff, 16'h0000, 1'b0);
		wait_idle();

		// zero limit holds every duty at zero
		load_gains(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 7'd0);
		add_tick(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b0);
		add_tick(16'd100, 16'd50, 16'hff9c, 16'd0, 1'b0);
		add_tick(16'h1234, 16'h4321, 16'hfedc, 16'hcdef, 1'b1);
		add_tick(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1'b0);
		add_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		wait_idle();

		// random phases, each under its own settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: load_gains(16'sd320, 16'sd24, 16'sd40, 16'sd64, 7'd90);
				1: load_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(), 7'd0);
				2: load_gains(16'h7fff, 16'h8000, 16'h0000, 16'sd128, 7'd1);
				3: load_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(), 7'd100);
				4: load_gains(16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 7'd127);
				5: load_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(), 7'd101);
				6: load_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
					LIM_W'($urandom_range(1, 100)));
				default: load_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
					LIM_W'($urandom_range(0, 127)));
			endcase
			add_random_ticks(115);
			wait_idle();
		end

		repeat (40) @(posedge clk);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
